>>> src/psim_pkg.sv
`default_nettype none

package psim_pkg;

   localparam int NUM_DIMS   = 3;
   localparam int SIZE_BITS  = 16;
   localparam int DIMS       = 3;
   localparam int COORD_W    = 18;
   localparam int CFG_W      = 16;
   localparam int DIV_W      = CFG_W + 1;
   localparam int IDX_W      = 48;
   localparam int CSR_IDX_W  = 3;
   localparam int STEPS      = 3;
   localparam int DIV_STAGES = COORD_W / STEPS;
   localparam logic [CFG_W-1:0] SIZE_MASK = CFG_W'((32'd1 << SIZE_BITS) - 32'd1);

   typedef enum logic [1:0] {
      MODE_CONST     = 2'd0,
      MODE_REFLECT   = 2'd1,
      MODE_REPLICATE = 2'd2,
      MODE_CIRCULAR  = 2'd3
   } pad_mode_type;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE0 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE1 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE2 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PAD0  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PAD1  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PAD2  = 3'd6;

   // per-dimension state carried down the remainder pipeline
   typedef struct packed {
      logic [COORD_W-1:0] rem;
      logic               neg;
      logic               oob;
      logic [CFG_W-1:0]   pre;
   } lane_type;

endpackage

`default_nettype wire

>>> src/pad_source_index_mapper.sv
// pipeline: req beat to rsp beat through 1 offset stage, 6 remainder
// stages of 3 compare-subtract steps each, 1 fold stage and 2 multiply stages
// throughput: one beat per cycle; the whole pipeline holds while rsp is stalled
// reset: synchronous, active high; clears all valid bits and sets mode constant,
// sizes 1 and pads 0
`default_nettype none

module pad_source_index_mapper (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_ready,
   input  wire  [psim_pkg::COORD_W-1:0]          req_out_coord_d0,
   input  wire  [psim_pkg::COORD_W-1:0]          req_out_coord_d1,
   input  wire  [psim_pkg::COORD_W-1:0]          req_out_coord_d2,
   output logic                                  rsp_valid,
   input  wire                                   rsp_ready,
   output logic [psim_pkg::IDX_W-1:0]            rsp_source_index,
   output logic                                  rsp_use_fill,
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [psim_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire  [psim_pkg::CFG_W-1:0]            csr_data
);
   import psim_pkg::*;

   // configuration registers
   pad_mode_type     mode_ff;
   logic [CFG_W-1:0] size_ff [DIMS];
   logic [CFG_W-1:0] pad_ff  [DIMS];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_CONST;
         for (int d = 0; d < DIMS; d++) begin
            size_ff[d] <= CFG_W'(1);
            pad_ff[d]  <= '0;
         end
      end else if (csr_valid) begin
         if (csr_index == CSR_MODE) begin
            mode_ff <= pad_mode_type'(csr_data[1:0]);
         end
         for (int d = 0; d < DIMS; d++) begin
            if (csr_index == CSR_SIZE0 + CSR_IDX_W'(d)) begin
               size_ff[d] <= csr_data & SIZE_MASK;
            end
            if (csr_index == CSR_PAD0 + CSR_IDX_W'(d)) begin
               pad_ff[d] <= csr_data & SIZE_MASK;
            end
         end
      end
   end

   // effective sizes: zero acts as one, inactive outer dims act as one
   logic [CFG_W-1:0] eff_size [DIMS];
   logic [DIV_W-1:0] divisor  [DIMS];
   logic             active   [DIMS];
   logic             unit     [DIMS];

   always_comb begin
      for (int d = 0; d < DIMS; d++) begin
         active[d]   = (d >= DIMS - NUM_DIMS);
         eff_size[d] = (!active[d] || size_ff[d] == '0) ? CFG_W'(1) : size_ff[d];
         unit[d]     = (eff_size[d] == CFG_W'(1));
         // reflect folds over period 2(size-1), circular over size
         divisor[d]  = (mode_ff == MODE_REFLECT) ? {eff_size[d] - CFG_W'(1), 1'b0}
                                                 : {1'b0, eff_size[d]};
      end
   end

   // whole pipeline advances together unless the output beat is stalled
   logic advance;
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // offset stage: x = coord - pad, magnitude, constant and clamp results
   logic [COORD_W-1:0] coord [DIMS];
   assign coord[0] = req_out_coord_d0;
   assign coord[1] = req_out_coord_d1;
   assign coord[2] = req_out_coord_d2;

   lane_type lane_in [DIMS];

   always_comb begin
      logic [COORD_W:0] x;
      logic             neg;
      logic             over;
      for (int d = 0; d < DIMS; d++) begin
         x    = {1'b0, coord[d]} - {{(COORD_W + 1 - CFG_W){1'b0}}, pad_ff[d]};
         neg  = x[COORD_W];
         over = !neg && (x[COORD_W-1:0] >= {{(COORD_W - CFG_W){1'b0}}, eff_size[d]});
         lane_in[d].neg = neg;
         lane_in[d].rem = neg ? COORD_W'(-x) : x[COORD_W-1:0];
         lane_in[d].oob = active[d] && (mode_ff == MODE_CONST) && (neg || over);
         if (mode_ff == MODE_CONST) begin
            lane_in[d].pre = x[CFG_W-1:0];
         end else if (neg) begin
            lane_in[d].pre = '0;
         end else if (over) begin
            lane_in[d].pre = eff_size[d] - CFG_W'(1);
         end else begin
            lane_in[d].pre = x[CFG_W-1:0];
         end
      end
   end

   // remainder pipeline: restoring long division, quotient bits msb first
   logic     div_valid_ff [DIV_STAGES+1];
   lane_type div_ff       [DIV_STAGES+1][DIMS];

   always_ff @(posedge clock) begin
      if (reset) begin
         div_valid_ff[0] <= 1'b0;
      end else if (advance) begin
         div_valid_ff[0] <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int d = 0; d < DIMS; d++) begin
            div_ff[0][d] <= lane_in[d];
         end
      end
   end

   for (genvar st = 0; st < DIV_STAGES; st++) begin : g_div
      lane_type div_in [DIMS];

      always_comb begin
         logic [COORD_W+DIV_W-1:0] shifted;
         logic [COORD_W+DIV_W-1:0] r;
         for (int d = 0; d < DIMS; d++) begin
            div_in[d] = div_ff[st][d];
            r = {{DIV_W{1'b0}}, div_ff[st][d].rem};
            for (int j = 0; j < STEPS; j++) begin
               shifted = {{COORD_W{1'b0}}, divisor[d]} << (COORD_W - 1 - st * STEPS - j);
               if (r >= shifted) begin
                  r = r - shifted;
               end
            end
            div_in[d].rem = r[COORD_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_valid_ff[st+1] <= 1'b0;
         end else if (advance) begin
            div_valid_ff[st+1] <= div_valid_ff[st];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            for (int d = 0; d < DIMS; d++) begin
               div_ff[st+1][d] <= div_in[d];
            end
         end
      end
   end

   // fold stage: turn remainder into an in-range coordinate per mode
   logic             fold_valid_ff;
   logic             fold_oob_ff;
   logic [CFG_W-1:0] fold_ic_ff [DIMS];
   logic [CFG_W-1:0] fold_ic_in [DIMS];
   logic             fold_oob_in;

   always_comb begin
      lane_type         ln;
      logic [DIV_W-1:0] r;
      fold_oob_in = 1'b0;
      for (int d = 0; d < DIMS; d++) begin
         ln = div_ff[DIV_STAGES][d];
         r  = {1'b0, ln.rem[CFG_W-1:0]} | {ln.rem[CFG_W], {CFG_W{1'b0}}};
         fold_oob_in = fold_oob_in | ln.oob;
         if (!active[d]) begin
            fold_ic_in[d] = '0;
         end else begin
            case (mode_ff)
               MODE_REFLECT: begin
                  if (unit[d]) begin
                     fold_ic_in[d] = '0;
                  end else if (r >= {1'b0, eff_size[d]}) begin
                     fold_ic_in[d] = CFG_W'(divisor[d] - r);
                  end else begin
                     fold_ic_in[d] = r[CFG_W-1:0];
                  end
               end
               MODE_CIRCULAR: begin
                  if (unit[d]) begin
                     fold_ic_in[d] = '0;
                  end else if (ln.neg && r != '0) begin
                     fold_ic_in[d] = eff_size[d] - r[CFG_W-1:0];
                  end else begin
                     fold_ic_in[d] = r[CFG_W-1:0];
                  end
               end
               default: begin
                  fold_ic_in[d] = ln.pre;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_valid_ff <= 1'b0;
      end else if (advance) begin
         fold_valid_ff <= div_valid_ff[DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fold_oob_ff <= fold_oob_in;
         for (int d = 0; d < DIMS; d++) begin
            fold_ic_ff[d] <= fold_ic_in[d];
         end
      end
   end

   // first multiply: outer and middle dims
   localparam int MID_W = 2 * CFG_W;
   logic             mul_valid_ff;
   logic             mul_oob_ff;
   logic [MID_W-1:0] mul_part_ff;
   logic [CFG_W-1:0] mul_ic2_ff;
   logic [MID_W-1:0] mul_part_in;

   assign mul_part_in = fold_ic_ff[0] * eff_size[1] + {{CFG_W{1'b0}}, fold_ic_ff[1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (advance) begin
         mul_valid_ff <= fold_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mul_oob_ff  <= fold_oob_ff;
         mul_part_ff <= mul_part_in;
         mul_ic2_ff  <= fold_ic_ff[2];
      end
   end

   // second multiply into the output register; fill forces index 0
   logic             out_valid_ff;
   logic             out_fill_ff;
   logic [IDX_W-1:0] out_index_ff;
   logic [IDX_W-1:0] out_index_in;

   assign out_index_in = mul_oob_ff ? '0
                       : IDX_W'(mul_part_ff) * IDX_W'(eff_size[2]) + IDX_W'(mul_ic2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_fill_ff  <= mul_oob_ff;
         out_index_ff <= out_index_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_use_fill     = out_fill_ff;
   assign rsp_source_index = out_index_ff;

endmodule

`default_nettype wire

>>> src/psim_checker.sv
`default_nettype none

module psim_checker (
   input wire                               clock,
   input wire                               reset,
   input wire                               req_ready,
   input wire                               rsp_valid,
   input wire                               rsp_ready,
   input wire [psim_pkg::IDX_W-1:0]         rsp_source_index,
   input wire                               rsp_use_fill
);
   import psim_pkg::*;

   // stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_source_index)
                                 && $stable(rsp_use_fill))
      else $error("rsp beat changed while stalled");

   // fill beats carry index zero
   a_fill_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_use_fill |-> rsp_source_index == '0)
      else $error("fill beat with nonzero index");

   // empty output never blocks the input
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req stalled with empty output");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind pad_source_index_mapper psim_checker u_psim_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_source_index (rsp_source_index),
   .rsp_use_fill     (rsp_use_fill)
);

`default_nettype wire

>>> tb/pad_index_checker.sv
`default_nettype none

module pad_index_checker (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   input  wire                           req_ready,
   input  wire  [psim_pkg::COORD_W-1:0]  req_out_coord_d0,
   input  wire  [psim_pkg::COORD_W-1:0]  req_out_coord_d1,
   input  wire  [psim_pkg::COORD_W-1:0]  req_out_coord_d2,
   input  wire                           rsp_valid,
   input  wire                           rsp_ready,
   input  wire  [psim_pkg::IDX_W-1:0]    rsp_source_index,
   input  wire                           rsp_use_fill,
   input  wire                           csr_valid,
   input  wire                           csr_ready,
   input  wire  [psim_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire  [psim_pkg::CFG_W-1:0]    csr_data,
   output int                            fail_count,
   output int                            pending_count
);
   import psim_pkg::*;

   typedef struct packed {
      logic [IDX_W-1:0] index;
      logic             fill;
   } mapped_type;

   pad_mode_type     cur_mode;
   logic [CFG_W-1:0] cur_size [3];
   logic [CFG_W-1:0] cur_pad  [3];
   mapped_type       mapped_q [$];

   function automatic longint fold_coord(longint x, longint s, pad_mode_type m,
                                         inout bit oob);
      longint period, r;
      if (m == MODE_CONST) begin
         if (x < 0 || x >= s) begin
            oob = 1;
            return 0;
         end
         return x;
      end
      if (s <= 1) return 0;
      if (m == MODE_REFLECT) begin
         period = 2 * (s - 1);
         r = ((x < 0) ? -x : x) % period;
         if (r >= s) r = period - r;
         return r;
      end
      if (m == MODE_CIRCULAR) begin
         r = x % s;
         if (r < 0) r += s;
         return r;
      end
      if (x < 0) return 0;
      if (x > s - 1) return s - 1;
      return x;
   endfunction

   function automatic mapped_type map_coord(logic [COORD_W-1:0] c0,
                                            logic [COORD_W-1:0] c1,
                                            logic [COORD_W-1:0] c2);
      logic [COORD_W-1:0] c [3];
      bit               oob;
      longint           s, x, ic;
      logic [IDX_W-1:0] idx;
      mapped_type       res;
      c[0] = c0; c[1] = c1; c[2] = c2;
      oob = 0;
      idx = '0;
      for (int d = 3 - NUM_DIMS; d < 3; d++) begin
         s = (cur_size[d] == 0) ? 1 : longint'(cur_size[d]);
         x = longint'(c[d]) - longint'(cur_pad[d]);
         ic = fold_coord(x, s, cur_mode, oob);
         idx = IDX_W'(idx * IDX_W'(s) + IDX_W'(ic));
      end
      res.fill = oob;
      res.index = oob ? '0 : idx;
      return res;
   endfunction

   assign pending_count = mapped_q.size();

   always @(posedge clock) begin
      mapped_type want;
      if (reset) begin
         cur_mode <= MODE_CONST;
         for (int d = 0; d < 3; d++) begin
            cur_size[d] <= 1;
            cur_pad[d]  <= 0;
         end
         fail_count <= 0;
         mapped_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_MODE)
               cur_mode <= pad_mode_type'(csr_data[1:0]);
            else if (csr_index >= CSR_SIZE0 && csr_index <= CSR_SIZE2)
               cur_size[csr_index - CSR_SIZE0] <= csr_data & SIZE_MASK;
            else if (csr_index >= CSR_PAD0 && csr_index <= CSR_PAD2)
               cur_pad[csr_index - CSR_PAD0] <= csr_data & SIZE_MASK;
         end
         if (req_valid && req_ready)
            mapped_q.push_back(map_coord(req_out_coord_d0, req_out_coord_d1,
                                         req_out_coord_d2));
         if (rsp_valid && rsp_ready) begin
            if (mapped_q.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10) $display("unexpected rsp beat idx=%0d fill=%0b",
                                             rsp_source_index, rsp_use_fill);
            end else begin
               want = mapped_q.pop_front();
               if (want.index !== rsp_source_index || want.fill !== rsp_use_fill) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("mismatch: exp idx=%0d fill=%0b got idx=%0d fill=%0b",
                              want.index, want.fill, rsp_source_index, rsp_use_fill);
               end
            end
         end
      end
   end
endmodule

`default_nettype wire

>>> tb/tb_pad_source_index_mapper.sv
`default_nettype none

module tb_pad_source_index_mapper;
   import psim_pkg::*;

   logic clock, reset;
   logic req_valid, req_ready;
   logic [COORD_W-1:0] req_out_coord_d0, req_out_coord_d1, req_out_coord_d2;
   logic rsp_valid, rsp_ready;
   logic [IDX_W-1:0] rsp_source_index;
   logic rsp_use_fill;
   logic csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0] csr_data;
   int fail_count, pending_count;

   // idle percentages for each side, and the long receiver hold-off
   int send_idle_pct, recv_idle_pct;
   bit recv_hold;
   int hold_cycles;

   localparam int LATENCY = 10;

   pad_source_index_mapper u_top (.*);

   pad_index_checker u_chk (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #(12 * 400000);
      $display("simulation failed");
      $finish;
   end

   // receiver: random stalls plus a long hold-off counted here
   initial begin
      rsp_ready = 0;
      hold_cycles = 0;
      forever begin
         @(posedge clock);
         if (recv_hold && hold_cycles < 200) begin
            hold_cycles <= hold_cycles + 1;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
   endtask

   // wait for the pipeline to drain before touching registers
   task automatic drain();
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic setup(pad_mode_type m, logic [CFG_W-1:0] s0, s1, s2, p0, p1, p2);
      drain();
      csr_write(CSR_MODE, CFG_W'(m));
      csr_write(CSR_SIZE0, s0);
      csr_write(CSR_SIZE1, s1);
      csr_write(CSR_SIZE2, s2);
      csr_write(CSR_PAD0, p0);
      csr_write(CSR_PAD1, p1);
      csr_write(CSR_PAD2, p2);
   endtask

   // one beat; sender may idle before offering it
   task automatic send_coord(logic [COORD_W-1:0] c0, c1, c2);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_out_coord_d0 <= c0;
      req_out_coord_d1 <= c1;
      req_out_coord_d2 <= c2;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic [COORD_W-1:0] pick_coord(logic [CFG_W-1:0] s,
                                                     logic [CFG_W-1:0] p);
      int r;
      r = $urandom_range(9);
      if (r == 0) return COORD_W'($urandom);
      if (r == 1) return COORD_W'(196605 - $urandom_range(3));
      if (r < 4) return COORD_W'($urandom_range(3));
      return COORD_W'(p + $urandom_range(3 * s + 4)) - COORD_W'($urandom_range(2 * s + 2));
   endfunction

   initial begin
      logic [CFG_W-1:0] sz [3];
      logic [CFG_W-1:0] pd [3];
      pad_mode_type m;
      reset = 1;
      req_valid = 0;
      req_out_coord_d0 = 0; req_out_coord_d1 = 0; req_out_coord_d2 = 0;
      csr_valid = 0; csr_index = 0; csr_data = 0;
      send_idle_pct = 16; recv_idle_pct = 55;
      recv_hold = 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset defaults: sizes 1, constant mode, only zero lies inside
      send_coord(0, 0, 0);
      send_coord(1, 0, 0);
      send_coord('1, '1, '1);
      req_valid <= 0;

      // each mode on small sizes, with edge coordinates
      for (int k = 0; k < 4; k++) begin
         setup(pad_mode_type'(k), 3, 1, 5, 2, 0, 4);
         send_coord(0, 0, 0);
         send_coord(1, 3, 6);
         send_coord(4, 0, 9);
         send_coord('1, 0, 196605);
         req_valid <= 0;
      end
      // size zero acts as one, maximum sizes and pads
      setup(MODE_REFLECT, 0, 2, 16'hffff, 16'hffff, 0, 16'hffff);
      send_coord(16'hffff, 0, 0);
      send_coord(0, 5, '1);
      req_valid <= 0;
      setup(MODE_CIRCULAR, 16'hffff, 16'hffff, 16'hffff, 0, 16'hffff, 0);
      send_coord(196605, 0, 16'hfffe);
      send_coord(16'hffff, '1, 196605);
      req_valid <= 0;

      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin send_idle_pct = 55; recv_idle_pct = 16; end
         if (phase == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
         for (int cfg = 0; cfg < 6; cfg++) begin
            m = pad_mode_type'($urandom_range(3));
            for (int d = 0; d < 3; d++) begin
               sz[d] = ($urandom_range(9) == 0) ? CFG_W'($urandom)
                                                : CFG_W'($urandom_range(12));
               pd[d] = ($urandom_range(9) == 0) ? CFG_W'($urandom)
                                                : CFG_W'($urandom_range(8));
            end
            setup(m, sz[0], sz[1], sz[2], pd[0], pd[1], pd[2]);
            // long receiver hold-off while the sender keeps offering
            if (phase == 0 && cfg == 2) recv_hold = 1;
            for (int n = 0; n < 28; n++)
               send_coord(pick_coord(sz[0], pd[0]), pick_coord(sz[1], pd[1]),
                          pick_coord(sz[2], pd[2]));
            req_valid <= 0;
            // sender pauses until every result is back
            if (cfg == 3) while (pending_count != 0) @(posedge clock);
         end
      end

      req_valid <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule

`default_nettype wire
